>>> src/bpc_pkg.sv
// Package for the barometric pressure compensation block.
// Holds the pipeline constants, field widths, register indexes and helper functions.
package bpc_pkg;

  localparam int RawTempWidth  = 16;
  localparam int RawPresWidth  = 19;
  localparam int CfgWidth      = 48;
  localparam int CfgIdxWidth   = 3;
  localparam int DivWidth      = 32;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxWidth-1:0] RegOffset = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegScale  = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegB      = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegM      = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegOss    = 3'd4;

  // Arithmetic shift right of a 32-bit word.
  function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
    asr32 = 32'($signed(v) >>> s);
  endfunction

  // Sign extension of a 16-bit coefficient.
  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

endpackage

>>> src/barometric_pressure_compensation.sv
// Barometric pressure compensation, fully pipelined: one word accepted per cycle.
// From start to out_valid a word passes two 32-stage dividers
// (temperature then pressure) plus nine arithmetic stages around them.
// Throughput is one word per cycle; busy is always low and the receiver cannot stall.
// Synchronous active-low reset clears all valid bits and the configuration registers.
module barometric_pressure_compensation (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [bpc_pkg::RawTempWidth-1:0]     in_raw_temperature,
  input  logic [bpc_pkg::RawPresWidth-1:0]     in_raw_pressure,
  output logic                                 out_valid,
  output logic signed [15:0]                   out_temperature_tenths,
  output logic signed [31:0]                   out_pressure_pa,
  output logic                                 out_divide_error,
  input  logic                                 cfg_we,
  input  logic [bpc_pkg::CfgIdxWidth-1:0]      cfg_index,
  input  logic [bpc_pkg::CfgWidth-1:0]         cfg_data
);
  import bpc_pkg::*;

  logic [47:0] offs_r, scale_r;
  logic [31:0] bw_r, mw_r;
  logic [1:0]  oss_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offs_r <= '0; scale_r <= '0; bw_r <= '0; mw_r <= '0; oss_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegOffset: offs_r  <= cfg_data;
        RegScale:  scale_r <= cfg_data;
        RegB:      bw_r    <= cfg_data[31:0];
        RegM:      mw_r    <= cfg_data[31:0];
        RegOss:    oss_r   <= cfg_data[1:0];
        default:   ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Temperature front end.
  logic        t_v, t_neg, t_dz;
  logic [31:0] t_x1, t_nm, t_dm;
  logic [RawPresWidth-1:0] t_up;
  bpc_temp u_temp (
    .clk, .rst_n, .in_valid(start), .in_ut(in_raw_temperature), .in_up(in_raw_pressure),
    .ac5(scale_r[31:16]), .ac6(scale_r[15:0]), .mc(mw_r[31:16]), .md(mw_r[15:0]),
    .out_valid(t_v), .out_x1(t_x1), .out_num_mag(t_nm), .out_den_mag(t_dm),
    .out_neg(t_neg), .out_dzero(t_dz), .out_up(t_up)
  );

  // Temperature divider; tag carries x1, sign, zero flag and raw pressure.
  localparam int TTagW = 32 + 2 + RawPresWidth;
  logic             td_v;
  logic [31:0]      td_q;
  logic [TTagW-1:0] td_tag;
  bpc_udiv #(.TagWidth(TTagW)) u_tdiv (
    .clk, .rst_n, .in_valid(t_v), .in_num(t_nm), .in_den(t_dm),
    .in_tag({t_x1, t_neg, t_dz, t_up}),
    .out_valid(td_v), .out_quo(td_q), .out_tag(td_tag)
  );

  // Stage: apply the quotient sign and form b5.
  logic        b5v_r, b5e_r;
  logic [31:0] b5_r, x2s;
  logic [RawPresWidth-1:0] b5up_r;
  always_comb x2s = td_tag[RawPresWidth+1] ? 32'(-td_q) : td_q;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b5v_r <= 1'b0;
    end else begin
      b5v_r <= td_v;
    end
    b5_r   <= td_tag[TTagW-1 -: 32] + x2s;
    b5e_r  <= td_tag[RawPresWidth];
    b5up_r <= td_tag[RawPresWidth-1:0];
  end

  // Pressure middle section.
  logic        p_v, p_e, p_big;
  logic [31:0] p_b5, p_num, p_b4;
  bpc_pres u_pres (
    .clk, .rst_n, .in_valid(b5v_r), .in_b5(b5_r), .in_err(b5e_r), .in_up(b5up_r),
    .ac1(offs_r[47:32]), .ac2(offs_r[31:16]), .ac3(offs_r[15:0]), .ac4(scale_r[47:32]),
    .b1(bw_r[31:16]), .b2(bw_r[15:0]), .oss(oss_r),
    .out_valid(p_v), .out_b5(p_b5), .out_err(p_e), .out_num(p_num), .out_b4(p_b4),
    .out_big(p_big)
  );

  // Pressure divider; tag carries b5, error and the large-b7 flag.
  localparam int PTagW = 34;
  logic             pd_v;
  logic [31:0]      pd_q;
  logic [PTagW-1:0] pd_tag;
  bpc_udiv #(.TagWidth(PTagW)) u_pdiv (
    .clk, .rst_n, .in_valid(p_v), .in_num(p_num), .in_den(p_b4),
    .in_tag({p_b5, p_e, p_big}),
    .out_valid(pd_v), .out_quo(pd_q), .out_tag(pd_tag)
  );

  // Final stage one: p, its squared term product and linear term.
  logic        f1v_r, f1e_r;
  logic [31:0] f1p_r, f1sq_r, f1lin_r, f1b5_r, p_nxt, ps;
  always_comb begin
    p_nxt = pd_tag[0] ? (pd_q << 1) : pd_q;
    ps    = asr32(p_nxt, 5'd8);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1v_r <= 1'b0;
    end else begin
      f1v_r <= pd_v;
    end
    f1e_r   <= pd_tag[1];
    f1b5_r  <= pd_tag[PTagW-1 -: 32];
    f1p_r   <= p_nxt;
    f1sq_r  <= 32'(ps * ps);
    f1lin_r <= asr32(32'(32'd0 - 32'(32'd7357 * p_nxt)), 5'd16);
  end

  // Final stage two: scale, sum and saturate.
  logic        f2v_r, f2e_r;
  logic [31:0] f2p_r, x1f, tsh;
  logic [15:0] f2t_r, t_sat;
  always_comb begin
    x1f = asr32(32'(f1sq_r * 32'd3038), 5'd16);
    tsh = asr32(f1b5_r + 32'd8, 5'd4);
    if ($signed(tsh) > 32'sd32767) begin
      t_sat = 16'h7fff;
    end else if ($signed(tsh) < -32'sd32768) begin
      t_sat = 16'h8000;
    end else begin
      t_sat = tsh[15:0];
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2v_r <= 1'b0;
    end else begin
      f2v_r <= f1v_r;
    end
    f2e_r <= f1e_r;
    f2t_r <= f1e_r ? '0 : t_sat;
    f2p_r <= f1e_r ? '0 : f1p_r + asr32(x1f + f1lin_r + 32'd3791, 5'd4);
  end

  assign out_valid              = f2v_r;
  assign out_temperature_tenths = f2t_r;
  assign out_pressure_pa        = f2p_r;
  assign out_divide_error       = f2e_r;

endmodule

>>> src/bpc_udiv.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on bpc_pkg for the word width; carries a tag alongside.
module bpc_udiv #(
  parameter int TagWidth = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [bpc_pkg::DivWidth-1:0] in_num,
  input  logic [bpc_pkg::DivWidth-1:0] in_den,
  input  logic [TagWidth-1:0]          in_tag,
  output logic                        out_valid,
  output logic [bpc_pkg::DivWidth-1:0] out_quo,
  output logic [TagWidth-1:0]          out_tag
);
  import bpc_pkg::*;

  localparam int N = DivWidth;

  logic             v_r   [N+1];
  logic [N-1:0]     rem_r [N+1];
  logic [N-1:0]     num_r [N+1];
  logic [N-1:0]     den_r [N+1];
  logic [TagWidth-1:0] tag_r [N+1];

  always_comb begin
    v_r[0]   = in_valid;
    rem_r[0] = '0;
    num_r[0] = in_num;
    den_r[0] = in_den;
    tag_r[0] = in_tag;
  end

  // Each stage brings down one numerator bit and tries one subtraction.
  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [N:0]   trial;
    logic [N:0]   diff;
    always_comb begin
      trial = {rem_r[i], num_r[i][N-1]};
      diff  = trial - {1'b0, den_r[i]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else begin
        v_r[i+1] <= v_r[i];
      end
      rem_r[i+1] <= diff[N] ? trial[N-1:0] : diff[N-1:0];
      num_r[i+1] <= {num_r[i][N-2:0], ~diff[N]};
      den_r[i+1] <= den_r[i];
      tag_r[i+1] <= tag_r[i];
    end
  end

  assign out_valid = v_r[N];
  assign out_quo   = num_r[N];
  assign out_tag   = tag_r[N];

endmodule

>>> src/bpc_temp.sv
// Temperature front end: x1 product, divider operands and b5 assembly helpers.
// Depends on bpc_pkg; its divider result is joined in the top level.
module bpc_temp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic [bpc_pkg::RawTempWidth-1:0]   in_ut,
  input  logic [bpc_pkg::RawPresWidth-1:0]   in_up,
  input  logic [15:0]                        ac5,
  input  logic [15:0]                        ac6,
  input  logic [15:0]                        mc,
  input  logic [15:0]                        md,
  output logic                               out_valid,
  output logic [31:0]                        out_x1,
  output logic [31:0]                        out_num_mag,
  output logic [31:0]                        out_den_mag,
  output logic                               out_neg,
  output logic                               out_dzero,
  output logic [bpc_pkg::RawPresWidth-1:0]   out_up
);
  import bpc_pkg::*;

  logic        v1_r, v2_r;
  logic [31:0] diff_r;
  logic [RawPresWidth-1:0] up1_r, up2_r;
  logic [31:0] x1_r, nm_r, dm_r;
  logic        neg_r, dz_r;
  logic [31:0] x1_nxt, d_nxt, n_nxt;

  // Stage one: subtract ac6.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    diff_r <= {16'd0, in_ut} - {16'd0, ac6};
    up1_r  <= in_up;
  end

  // Stage two: product, shift, and signed-divide operand magnitudes.
  always_comb begin
    x1_nxt = asr32(32'(diff_r * {16'd0, ac5}), 5'd15);
    d_nxt  = x1_nxt + sx16(md);
    n_nxt  = sx16(mc) << 11;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    x1_r  <= x1_nxt;
    nm_r  <= n_nxt[31] ? 32'(-n_nxt) : n_nxt;
    dm_r  <= d_nxt[31] ? 32'(-d_nxt) : d_nxt;
    neg_r <= n_nxt[31] ^ d_nxt[31];
    dz_r  <= (d_nxt == '0);
    up2_r <= up1_r;
  end

  assign out_valid   = v2_r;
  assign out_x1      = x1_r;
  assign out_num_mag = nm_r;
  assign out_den_mag = dm_r;
  assign out_neg     = neg_r;
  assign out_dzero   = dz_r;
  assign out_up      = up2_r;

endmodule

>>> src/bpc_pres.sv
// Pressure middle section: from b5 to the b7 dividend and the b4 divisor.
// Depends on bpc_pkg; a multi-stage pipeline whose products are formed in stages B, C and D.
module bpc_pres (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic [31:0]                      in_b5,
  input  logic                             in_err,
  input  logic [bpc_pkg::RawPresWidth-1:0] in_up,
  input  logic [15:0]                      ac1,
  input  logic [15:0]                      ac2,
  input  logic [15:0]                      ac3,
  input  logic [15:0]                      ac4,
  input  logic [15:0]                      b1,
  input  logic [15:0]                      b2,
  input  logic [1:0]                       oss,
  output logic                             out_valid,
  output logic [31:0]                      out_b5,
  output logic                             out_err,
  output logic [31:0]                      out_num,
  output logic [31:0]                      out_b4,
  output logic                             out_big
);
  import bpc_pkg::*;

  // Stage A: b6; stage B then forms sq, ac2*b6 and ac3*b6.
  logic        va_r, vb_r, vc_r, vd_r;
  logic [31:0] b5a_r, b6a_r;
  logic        ea_r;
  logic [RawPresWidth-1:0] upa_r, upb_r, upc_r;
  logic [31:0] b6_nxt;

  always_comb b6_nxt = in_b5 - 32'd4000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= in_valid;
    end
    b5a_r <= in_b5;
    b6a_r <= b6_nxt;
    ea_r  <= in_err;
    upa_r <= in_up;
  end

  // Stage B: products on b6.
  logic [31:0] b5b_r, sq_r, p2_r, p3_r;
  logic        eb_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
    b5b_r <= b5a_r;
    eb_r  <= ea_r;
    upb_r <= upa_r;
    sq_r  <= asr32(32'(b6a_r * b6a_r), 5'd12);
    p2_r  <= asr32(32'(sx16(ac2) * b6a_r), 5'd11);
    p3_r  <= asr32(32'(sx16(ac3) * b6a_r), 5'd13);
  end

  // Stage C: b3 and the b4 operand x3.
  logic [31:0] b5c_r, b3_r, x3_r;
  logic        ec_r;
  logic [31:0] t1, t2, s3;
  always_comb begin
    t1 = asr32(32'(sx16(b2) * sq_r), 5'd11);
    t2 = asr32(32'(sx16(b1) * sq_r), 5'd16);
    s3 = ((32'(sx16(ac1) << 2) + t1 + p2_r) << oss) + 32'd2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else begin
      vc_r <= vb_r;
    end
    b5c_r <= b5b_r;
    ec_r  <= eb_r;
    upc_r <= upb_r;
    b3_r  <= asr32(s3, 5'd2);
    x3_r  <= asr32(p3_r + t2 + 32'd2, 5'd2) + 32'd32768;
  end

  // Stage D: b4 and b7.
  logic [31:0] b5d_r, num_r, b4_r, b4_nxt, b7_nxt, scl;
  logic        ed_r, big_r;
  always_comb begin
    b4_nxt = 32'({16'd0, ac4} * x3_r) >> 15;
    scl    = 32'd50000 >> oss;
    b7_nxt = 32'(({13'd0, upc_r} - b3_r) * scl);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else begin
      vd_r <= vc_r;
    end
    b5d_r <= b5c_r;
    b4_r  <= b4_nxt;
    ed_r  <= ec_r | (b4_nxt == '0);
    big_r <= b7_nxt[31];
    num_r <= b7_nxt[31] ? b7_nxt : (b7_nxt << 1);
  end

  assign out_valid = vd_r;
  assign out_b5    = b5d_r;
  assign out_err   = ed_r;
  assign out_num   = num_r;
  assign out_b4    = b4_r;
  assign out_big   = big_r;

endmodule

>>> dv/barometric_pressure_compensation_tb.sv
// Testbench for the barometric pressure compensation block.
// Depends on bpc_pkg and the block; predicts each result word in integer arithmetic and checks it.
module barometric_pressure_compensation_tb;
  import bpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency   = 73;
  localparam int IdleLimit = 4000;

  typedef struct packed {
    logic signed [15:0] temp;
    logic signed [31:0] pres;
    logic               derr;
  } comp_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [RawTempWidth-1:0] in_raw_temperature = '0;
  logic [RawPresWidth-1:0] in_raw_pressure = '0;
  logic out_valid;
  logic signed [15:0] out_temperature_tenths;
  logic signed [31:0] out_pressure_pa;
  logic out_divide_error;
  logic cfg_we = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_index = '0;
  logic [CfgWidth-1:0] cfg_data = '0;

  // Calibration copy used by the predictor.
  logic [47:0] cal_off, cal_scl;
  logic [31:0] cal_b, cal_m;
  logic [1:0]  oss_set;

  comp_word_t expected_words[$];
  int errors = 0;
  int words_checked = 0;
  int div_errors_seen = 0;
  int idle_cycles = 0;

  barometric_pressure_compensation i_dut (.*);

  always #5 clk = ~clk;

  function automatic logic [31:0] sra(input logic [31:0] v, input int s);
    return 32'($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] sext(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Signed division toward zero on 32-bit words; the one overflow case wraps.
  function automatic logic [31:0] sdiv32(input logic [31:0] n, input logic [31:0] d);
    longint q;
    q = longint'($signed(n)) / longint'($signed(d));
    return q[31:0];
  endfunction

  // Compensated temperature and pressure for one pair of raw readings.
  function automatic comp_word_t compensate(input logic [15:0] ut, input logic [18:0] up);
    comp_word_t r;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] x1, x2, x3, d, b5, b6, b3, b4, b7, sq, p, t32;
    int t;
    ac1 = sext(cal_off[47:32]); ac2 = sext(cal_off[31:16]); ac3 = sext(cal_off[15:0]);
    ac4 = {16'd0, cal_scl[47:32]}; ac5 = {16'd0, cal_scl[31:16]};
    ac6 = {16'd0, cal_scl[15:0]};
    b1 = sext(cal_b[31:16]); b2 = sext(cal_b[15:0]);
    mc = sext(cal_m[31:16]); md = sext(cal_m[15:0]);
    r = '0;
    x1 = sra(({16'd0, ut} - ac6) * ac5, 15);
    d = x1 + md;
    if (d == 0) begin
      r.derr = 1'b1;
      return r;
    end
    x2 = sdiv32(mc << 11, d);
    b5 = x1 + x2;
    t32 = sra(b5 + 32'd8, 4);
    t = $signed(t32);
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    b6 = b5 - 32'd4000;
    sq = sra(b6 * b6, 12);
    x1 = sra(b2 * sq, 11);
    x2 = sra(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = sra(((ac1 * 32'd4 + x3) << oss_set) + 32'd2, 2);
    x1 = sra(ac3 * b6, 13);
    x2 = sra(b1 * sq, 16);
    x3 = sra(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + 32'd32768)) >> 15;
    if (b4 == 0) begin
      r.derr = 1'b1;
      return r;
    end
    b7 = ({13'd0, up} - b3) * (32'd50000 >> oss_set);
    if (b7 < 32'h8000_0000) p = (b7 << 1) / b4;
    else p = (b7 / b4) << 1;
    x1 = sra(p, 8) * sra(p, 8);
    x1 = sra(x1 * 32'd3038, 16);
    x2 = sra(32'd0 - 32'd7357 * p, 16);
    p = p + sra(x1 + x2 + 32'd3791, 4);
    r.temp = 16'(t);
    r.pres = p;
    return r;
  endfunction

  // Checks every result word against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        $error("result word with no prediction pending");
        errors++;
      end else begin
        comp_word_t e;
        e = expected_words.pop_front();
        words_checked++;
        if (out_divide_error) div_errors_seen++;
        if (out_temperature_tenths !== e.temp) begin
          $error("temperature_tenths: expected %0d, got %0d", e.temp, out_temperature_tenths);
          errors++;
        end
        if (out_pressure_pa !== e.pres) begin
          $error("pressure_pa: expected %0d, got %0d", e.pres, out_pressure_pa);
          errors++;
        end
        if (out_divide_error !== e.derr) begin
          $error("divide_error: expected %0b, got %0b", e.derr, out_divide_error);
          errors++;
        end
      end
    end
  end

  // Watchdog: ends the run when no word goes in or out and no register is written for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog expired with %0d words outstanding", expected_words.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Drops start for a random number of cycles; a zero-length gap leaves it high.
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Holds the write enable high; the caller drops it after the last write.
  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [47:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      RegOffset: cal_off = val;
      RegScale:  cal_scl = val;
      RegB:      cal_b = val[31:0];
      RegM:      cal_m = val[31:0];
      RegOss:    oss_set = val[1:0];
      default: ;
    endcase
  endtask

  // Waits until every predicted word has come, then lets the pipeline drain.
  task automatic drain();
    while (expected_words.size() != 0) @(posedge clk);
    repeat (Latency + 5) @(posedge clk);
  endtask

  task automatic load_cal(input logic [47:0] off, input logic [47:0] scl,
                          input logic [31:0] b, input logic [31:0] m, input logic [1:0] o);
    drain();
    write_reg(RegOffset, off);
    write_reg(RegScale, scl);
    write_reg(RegB, {16'd0, b});
    write_reg(RegM, {16'd0, m});
    write_reg(RegOss, {46'd0, o});
    cfg_we <= 1'b0;
  endtask

  // Sends one word; start stays high while back-to-back words follow.
  task automatic send_word(input logic [15:0] ut, input logic [18:0] up, input bit gaps);
    start <= 1'b1;
    in_raw_temperature <= ut;
    in_raw_pressure <= up;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_words.push_back(compensate(ut, up));
    if (gaps && $urandom_range(0, 1)) idle_gap();
  endtask

  task automatic close_burst();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Datasheet-like calibration: realistic readings.
  task automatic load_typical(input logic [1:0] o);
    load_cal({16'd408, -16'sd72, -16'sd14383}, {16'd32741, 16'd32757, 16'd23153},
             {16'd6190, 16'd4}, {-16'sd8711, 16'd2868}, o);
  endtask

  task automatic test_directed_extremes();
    load_typical(2'd0);
    send_word(16'd27898, 19'd23843, 1'b0);
    send_word(16'h0000, 19'h00000, 1'b0);
    send_word(16'hFFFF, 19'h7FFFF, 1'b0);
    send_word(16'h8000, 19'h40000, 1'b0);
    send_word(16'h5555, 19'h2AAAA, 1'b0);
    send_word(16'hAAAA, 19'h55555, 1'b0);
    close_burst();
    // Extreme coefficients and oversampling.
    load_cal(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_7FFF, 2'd3);
    send_word(16'hFFFF, 19'h7FFFF, 1'b0);
    send_word(16'h0000, 19'h00000, 1'b0);
    send_word(16'h1234, 19'h12345, 1'b0);
    close_burst();
    load_cal(48'h8000_8000_8000, 48'h0001_FFFF_0000, 32'h8000_8000, 32'h8000_7FFF, 2'd1);
    send_word(16'hFFFF, 19'h7FFFF, 1'b0);
    send_word(16'h0000, 19'h00001, 1'b0);
    close_burst();
  endtask

  task automatic test_divide_by_zero();
    // All registers zero: temperature divisor is zero.
    load_cal('0, '0, '0, '0, 2'd0);
    send_word(16'd1000, 19'd1000, 1'b0);
    send_word(16'hFFFF, 19'h7FFFF, 1'b0);
    close_burst();
    // AC5 zero keeps X1 zero, MD nonzero; AC4 zero makes the pressure divisor zero.
    load_cal(48'd0, {16'd0, 16'd0, 16'd0}, 32'd0, {16'd0, 16'd1}, 2'd2);
    send_word(16'd5, 19'd5, 1'b0);
    close_burst();
    // Very negative B3 and huge raw pressure with low oversampling.
    load_cal({16'h8000, 16'd0, 16'd0}, {16'd1, 16'd0, 16'd0}, 32'd0, {16'd0, 16'd1}, 2'd0);
    send_word(16'd7, 19'h7FFFF, 1'b0);
    send_word(16'd7, 19'd0, 1'b0);
    close_burst();
  endtask

  task automatic test_random_typical();
    for (int o = 0; o < 4; o++) begin
      load_typical(2'(o));
      for (int i = 0; i < 60; i++)
        send_word(16'($urandom_range(20000, 36000)), 19'($urandom_range(0, 'h7FFFF)), 1'b1);
      close_burst();
    end
  endtask

  task automatic test_random_calibration();
    for (int s = 0; s < 6; s++) begin
      load_cal(48'({$urandom, $urandom}), 48'({$urandom, $urandom}), $urandom,
               $urandom_range(0, 7) == 0 ? 32'd0 : $urandom, 2'($urandom));
      for (int i = 0; i < 35; i++)
        send_word(16'($urandom), 19'($urandom), 1'b1);
      close_burst();
    end
  endtask

  initial begin
    cal_off = '0; cal_scl = '0; cal_b = '0; cal_m = '0; oss_set = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_divide_by_zero();
    test_random_typical();
    test_random_calibration();
    drain();
    $display("Checked %0d result words (%0d with divide error) over several calibrations,",
             words_checked, div_errors_seen);
    $display("all oversampling settings, extreme readings and random idle gaps.");
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
